// ===== design/universal_hash_dns_key_core_assert.svh =====
// ----------------------------------------------------------------------------
// universal_hash_dns_key_core_assert.svh
// assertion macros used by the hash core checker
// ----------------------------------------------------------------------------
`ifndef UNIVERSAL_HASH_DNS_KEY_CORE_ASSERT_SVH
`define UNIVERSAL_HASH_DNS_KEY_CORE_ASSERT_SVH

// same-cycle implication
`define UHDK_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uhdk assertion failed");

// next-cycle implication
`define UHDK_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uhdk assertion failed");

`endif

// ===== design/uhdk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhdk_pkg
// shared constants and command codes of the universal hash core
// ----------------------------------------------------------------------------
package uhdk_pkg;

	localparam int DATA_W         = 32;
	localparam int COEF_W         = 16;
	localparam int BYTE_W         = 8;
	localparam int CMD_W          = 2;
	localparam int REG_IDX_W      = 2;
	localparam int COEF_DEPTH_DEF = 256;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_KEY    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_TABLE_SIZE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MAX_KEY_LEN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HASH_PRIME  = 2'd2;

	localparam logic [DATA_W-1:0] TABLE_SIZE_RST  = 32'd1;
	localparam logic [BYTE_W-1:0] MAX_KEY_LEN_RST = 8'd253;
	localparam logic [DATA_W-1:0] HASH_PRIME_RST  = 32'hffff_fffb;

	localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

endpackage

// ===== design/uhdk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhdk_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module uhdk_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/uhdk_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhdk_mod_unit
// iterative remainder unit, one quotient bit per cycle, zero divisor passes
// ----------------------------------------------------------------------------
module uhdk_mod_unit
	import uhdk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] result
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] dsr_q;
	logic [DATA_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, dvd_q[DATA_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= (start && divisor == '0) || (!start && busy_q && cnt_q == '0);
			if (start) begin
				if (divisor != '0) begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DATA_W - 1);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (divisor == '0) ? dividend : '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DATA_W'(trial - {1'b0, dsr_q}) : trial[DATA_W-1:0];
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
		end
	end

	assign done   = done_q;
	assign result = rem_q;

endmodule

// ===== design/universal_hash_dns_key_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// universal_hash_dns_key_core
// multiply-accumulate hash of a name key and class code, reduced mod prime
// and mod table size
// ----------------------------------------------------------------------------
// usage
//  item channel (item_valid/item_ready) carries one command per transfer:
//  load a coefficient, add a key byte, or add the class code and finish.
//  hash channel (hash_valid/hash_ready) carries one bucket index per finish.
//  a key byte is a coefficient ram read, then one multiply-add; a finish is
//  three multiply-adds through the ram read port, then two passes of the
//  shared remainder unit. a zero modulus skips its pass.
//  item_ready is high only while the sequencer is idle; a result waiting in
//  the output register does not hold up loads or key bytes, but the next
//  finish waits until the receiver takes the earlier result.
//  reset clears accumulator, position and handshake state and loads the
//  default registers; coefficient ram contents are undefined until loaded.
//  configuration writes (cfg_we) take effect at once; the user must issue
//  them only while the core is idle, as the core does not enforce it.
// ----------------------------------------------------------------------------
module universal_hash_dns_key_core
	import uhdk_pkg::*;
#(
	parameter int COEF_DEPTH = COEF_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  logic [CMD_W-1:0]     cmd,
	input  logic [BYTE_W-1:0]    coef_index,
	input  logic [COEF_W-1:0]    coef_value,
	input  logic [BYTE_W-1:0]    key_byte,
	input  logic                 ignore_case,
	input  logic [COEF_W-1:0]    rr_class,
	output logic                 hash_valid,
	input  logic                 hash_ready,
	output logic [DATA_W-1:0]    hash_value
);

	localparam int PTR_W = $clog2(COEF_DEPTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MAC    = 3'd1;
	localparam logic [2:0] ST_P_GO   = 3'd2;
	localparam logic [2:0] ST_P_WAIT = 3'd3;
	localparam logic [2:0] ST_T_GO   = 3'd4;
	localparam logic [2:0] ST_T_WAIT = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	logic [2:0]        state_q;
	logic [DATA_W-1:0] table_size_q;
	logic [BYTE_W-1:0] max_key_len_q;
	logic [DATA_W-1:0] hash_prime_q;
	logic [DATA_W-1:0] acc_q;
	logic [BYTE_W-1:0] pos_q;
	logic [PTR_W-1:0]  ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [1:0]        step_q;
	logic              fin_q;
	logic [BYTE_W-1:0] op_q;
	logic [BYTE_W-1:0] cls_hi_q;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;

	logic                  accept;
	logic                  coef_we;
	logic [PTR_W-1:0]      raddr;
	logic [PTR_W-1:0]      rd_ptr_nxt;
	logic [COEF_W-1:0]     coef_rd;
	logic [BYTE_W+COEF_W-1:0] prod;
	logic                  mod_start;
	logic [DATA_W-1:0]     mod_divisor;
	logic                  mod_done;
	logic [DATA_W-1:0]     mod_result;
	logic [BYTE_W-1:0]     key_folded;

	function automatic logic [PTR_W-1:0] ptr_step(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(COEF_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	assign accept     = item_valid && item_ready;
	assign item_ready = (state_q == ST_IDLE);
	assign coef_we    = accept && (cmd == CMD_LOAD) &&
	                    ({1'b0, coef_index} < 9'(COEF_DEPTH));
	assign key_folded = (ignore_case && key_byte >= CHAR_UPPER_A && key_byte <= CHAR_UPPER_Z) ?
	                    BYTE_W'(key_byte + CASE_OFFSET) : key_byte;
	assign rd_ptr_nxt = ptr_step(rd_ptr_q);
	assign raddr      = (state_q == ST_IDLE) ? ptr_q : rd_ptr_nxt;
	assign prod       = op_q * coef_rd;
	assign mod_start  = (state_q == ST_P_GO) || (state_q == ST_T_GO);
	assign mod_divisor = (state_q == ST_P_GO) ? hash_prime_q : table_size_q;

	uhdk_ram #(
		.WIDTH(COEF_W),
		.DEPTH(COEF_DEPTH)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_index[PTR_W-1:0]),
		.wdata(coef_value),
		.raddr(raddr),
		.rdata(coef_rd)
	);

	uhdk_mod_unit u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(acc_q),
		.divisor (mod_divisor),
		.done    (mod_done),
		.result  (mod_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q  <= TABLE_SIZE_RST;
			max_key_len_q <= MAX_KEY_LEN_RST;
			hash_prime_q  <= HASH_PRIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_SIZE:  table_size_q  <= cfg_data;
				REG_MAX_KEY_LEN: max_key_len_q <= cfg_data[BYTE_W-1:0];
				REG_HASH_PRIME:  hash_prime_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			acc_q       <= '0;
			pos_q       <= '0;
			ptr_q       <= '0;
			rd_ptr_q    <= '0;
			step_q      <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_valid_q || hash_ready)) begin
				out_valid_q <= 1'b1;
			end else if (hash_valid && hash_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					rd_ptr_q <= ptr_q;
					step_q   <= '0;
					if (accept) begin
						if (cmd == CMD_KEY && pos_q < max_key_len_q) begin
							fin_q   <= 1'b0;
							state_q <= ST_MAC;
						end else if (cmd == CMD_FINISH) begin
							fin_q   <= 1'b1;
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					acc_q    <= acc_q + DATA_W'(prod);
					rd_ptr_q <= rd_ptr_nxt;
					step_q   <= step_q + 1'b1;
					if (!fin_q) begin
						pos_q   <= pos_q + 1'b1;
						ptr_q   <= ptr_step(ptr_q);
						state_q <= ST_IDLE;
					end else if (step_q == 2'd2) begin
						state_q <= ST_P_GO;
					end
				end
				ST_P_GO: begin
					state_q <= ST_P_WAIT;
				end
				ST_P_WAIT: begin
					if (mod_done) begin
						acc_q   <= mod_result;
						state_q <= ST_T_GO;
					end
				end
				ST_T_GO: begin
					state_q <= ST_T_WAIT;
				end
				ST_T_WAIT: begin
					if (mod_done) begin
						acc_q   <= mod_result;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || hash_ready) begin
						acc_q       <= '0;
						pos_q       <= '0;
						ptr_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			op_q     <= (cmd == CMD_FINISH) ? rr_class[BYTE_W-1:0] : key_folded;
			cls_hi_q <= rr_class[COEF_W-1:BYTE_W];
		end else if (state_q == ST_MAC) begin
			op_q <= (step_q == 2'd0) ? cls_hi_q : BYTE_W'(1);
		end
		if (state_q == ST_OUT && (!out_valid_q || hash_ready)) begin
			out_data_q <= acc_q;
		end
	end

	assign hash_valid = out_valid_q;
	assign hash_value = out_data_q;

endmodule

// ===== design/uhdk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uhdk_checker
// port-level checks of the hash core, bound to the top level
// ----------------------------------------------------------------------------
`include "universal_hash_dns_key_core_assert.svh"

module uhdk_checker
	import uhdk_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic [CMD_W-1:0]  cmd,
	input logic              hash_valid,
	input logic              hash_ready,
	input logic [DATA_W-1:0] hash_value
);

	`UHDK_ASSERT_NXT(a_hash_hold, clk, arst_n, hash_valid && !hash_ready, hash_valid && $stable(hash_value))
	`UHDK_ASSERT_NXT(a_finish_busy, clk, arst_n, item_valid && item_ready && cmd == CMD_FINISH, !item_ready)
	`UHDK_ASSERT_NXT(a_load_one_cycle, clk, arst_n, item_valid && item_ready && cmd == CMD_LOAD, item_ready)
	`UHDK_ASSERT_IMP(a_result_frees_input, clk, arst_n, $rose(hash_valid), item_ready)

endmodule

bind universal_hash_dns_key_core uhdk_checker u_uhdk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.cmd       (cmd),
	.hash_valid(hash_valid),
	.hash_ready(hash_ready),
	.hash_value(hash_value)
);
